// ===== rtl/core/glrp_pkg.sv =====
// Package for the greedy least-loaded row packer.
// Holds field widths, register indexes, word types and the saturation helper.
// Depends on nothing; glrp_scan and the top-level file in rtl/core refer to it by scoped names.
package glrp_pkg;

   localparam int FILL_W      = 16;
   localparam int ITEM_W      = 12;
   localparam int PAD_W       = 8;
   localparam int ROWCNT_W    = 5;
   localparam int ROW_W       = 4;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int MAX_ROWS_DEFAULT = 16;

   localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET = 5'd1;
   localparam logic [PAD_W-1:0]    PADDING_RESET   = 8'd4;

   localparam logic [CSR_ADDR_W-1:0] REG_ROW_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PADDING   = 2'd1;

   typedef struct packed {
      logic [ITEM_W-1:0] item_width;
      logic              last_item;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row_index;
      logic [FILL_W-1:0] x_offset;
      logic              batch_done;
      logic [FILL_W-1:0] max_row_width;
   } rsp_type;

   // Clamps a sum of at most three fill-sized terms to the fill range.
   function automatic logic [FILL_W-1:0] sat_fill(input logic [FILL_W+1:0] v);
      logic [FILL_W-1:0] r;
      if (v[FILL_W+1:FILL_W] != 2'b00) begin
         r = '1;
      end else begin
         r = v[FILL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/glrp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; width and depth come from parameters.
module glrp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/glrp_scan.sv =====
// Running minimum / maximum tracker fed one row fill per cycle by the sequencer.
// Depends on glrp_pkg for the fill width and the default row count.
module glrp_scan #(
   parameter int MAX_ROWS = glrp_pkg::MAX_ROWS_DEFAULT,
   localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      in_valid,
   input  logic [IDX_W-1:0]          in_idx,
   input  logic [glrp_pkg::FILL_W-1:0] in_fill,
   output logic [IDX_W-1:0]          best_idx,
   output logic [glrp_pkg::FILL_W-1:0] best_fill,
   output logic [glrp_pkg::FILL_W-1:0] max_fill
);

   logic                        first_ff, first_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   logic [glrp_pkg::FILL_W-1:0] best_fill_ff, best_fill_in;
   logic [glrp_pkg::FILL_W-1:0] max_fill_ff, max_fill_in;

   // Strict less-than keeps the lowest row index on a tie.
   always_comb begin
      first_in     = first_ff;
      best_idx_in  = best_idx_ff;
      best_fill_in = best_fill_ff;
      max_fill_in  = max_fill_ff;
      if (start) begin
         first_in = 1'b1;
      end else if (in_valid) begin
         first_in = 1'b0;
         if (first_ff || (in_fill < best_fill_ff)) begin
            best_idx_in  = in_idx;
            best_fill_in = in_fill;
         end
         if (first_ff || (in_fill > max_fill_ff)) begin
            max_fill_in = in_fill;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
      best_idx_ff  <= best_idx_in;
      best_fill_ff <= best_fill_in;
      max_fill_ff  <= max_fill_in;
   end

   assign best_idx  = best_idx_ff;
   assign best_fill = best_fill_ff;
   assign max_fill  = max_fill_ff;

endmodule

// ===== rtl/core/greedy_least_loaded_row_packer_top.sv =====
// Top level of the greedy least-loaded row packer: sequencer, row valid bits,
// configuration registers and result register.
// Depends on glrp_pkg, glrp_ram and glrp_scan.
//
// Usage:
//   The req channel takes one word per item (item_width, last_item). The item
//   goes to the row in use with the smallest fill, lowest index on a tie. The
//   rsp channel returns one word per item: row_index, x_offset, batch_done,
//   and on the last item of a batch the widest row in max_row_width.
//   After acceptance an item is placed by scanning N rows, where N is
//   the number of rows in use (row_count clamped to 1..MAX_ROWS): the fill
//   memory has a single registered read port, so the rows are read one per
//   cycle and compared by one min/max unit, followed by an update step.
//   A new word is accepted only after the update of the previous one.
//   req_ready is high while the sequencer is idle, also while a result waits.
//   If the receiver stalls, the next item is scanned and then held until the
//   result register frees up. The csr port writes row_count (index 0) and
//   padding (index 1); writes to other indexes are ignored. Write it only
//   while the block is idle.
//   Reset is synchronous: registers return to row_count 1 and padding 4, and
//   all row fills read as zero at once through per-row valid bits, which are
//   also cleared together at the end of each batch.
module greedy_least_loaded_row_packer_top #(
   parameter int MAX_ROWS = glrp_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  glrp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output glrp_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [glrp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [glrp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W = $clog2(MAX_ROWS + 1);
   localparam int CMP_W = CNT_W + glrp_pkg::ROWCNT_W;
   localparam int FW    = glrp_pkg::FILL_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [glrp_pkg::ROWCNT_W-1:0]   row_count_ff;
   logic [glrp_pkg::PAD_W-1:0]      padding_ff;
   glrp_pkg::req_type               item_ff;
   logic [CNT_W-1:0]                rows_ff, rows_in;
   logic [CNT_W-1:0]                issue_ff, issue_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]                rd_idx_ff;
   logic                            rd_vb_ff;
   logic [MAX_ROWS-1:0]             row_vld_ff, row_vld_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   glrp_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                            accept;
   logic                            issue;
   logic                            finish;
   logic [IDX_W-1:0]                rd_addr;
   logic [FW-1:0]                   ram_rdata;
   logic [FW-1:0]                   scan_fill;
   logic [IDX_W-1:0]                best_idx;
   logic [FW-1:0]                   best_fill;
   logic [FW-1:0]                   max_fill;
   logic [FW-1:0]                   new_fill;
   logic [FW-1:0]                   widest;
   logic [FW+1:0]                   pad_ext;
   logic [CMP_W-1:0]                rc_ext;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= glrp_pkg::ROW_COUNT_RESET;
         padding_ff   <= glrp_pkg::PADDING_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            glrp_pkg::REG_ROW_COUNT: row_count_ff <= csr_wdata[glrp_pkg::ROWCNT_W-1:0];
            glrp_pkg::REG_PADDING:   padding_ff   <= csr_wdata[glrp_pkg::PAD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- sequencer
   assign accept  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign issue   = (state_ff == ST_SCAN) && (issue_ff != rows_ff);
   assign finish  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rd_addr = issue_ff[IDX_W-1:0];
   assign rc_ext  = CMP_W'(row_count_ff);

   always_comb begin
      if (row_count_ff == '0) begin
         rows_in = CNT_W'(1);
      end else if (rc_ext > CMP_W'(MAX_ROWS)) begin
         rows_in = CNT_W'(MAX_ROWS);
      end else begin
         rows_in = rc_ext[CNT_W-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      issue_in    = issue_ff;
      rd_valid_in = issue;
      unique case (state_ff)
         ST_IDLE: begin
            issue_in = '0;
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               issue_in = issue_ff + CNT_W'(1);
            end else if (!rd_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         issue_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         issue_ff    <= issue_in;
         rd_valid_ff <= rd_valid_in;
      end
      rd_idx_ff <= rd_addr;
      rd_vb_ff  <= row_vld_ff[rd_addr];
      if (accept) begin
         item_ff <= req_data;
         rows_ff <= rows_in;
      end
   end

   // ----------------------------------------------------- fill storage
   glrp_ram #(
      .WIDTH (FW),
      .DEPTH (MAX_ROWS)
   ) u_fill_ram (
      .clock (clock),
      .we    (finish),
      .waddr (best_idx),
      .wdata (new_fill),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // A row that has not been written since the last batch reads as empty.
   assign scan_fill = rd_vb_ff ? ram_rdata : '0;

   always_comb begin
      row_vld_in = row_vld_ff;
      if (finish) begin
         if (item_ff.last_item) begin
            row_vld_in = '0;
         end else begin
            row_vld_in[best_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else begin
         row_vld_ff <= row_vld_in;
      end
   end

   glrp_scan #(
      .MAX_ROWS (MAX_ROWS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .in_valid  (rd_valid_ff),
      .in_idx    (rd_idx_ff),
      .in_fill   (scan_fill),
      .best_idx  (best_idx),
      .best_fill (best_fill),
      .max_fill  (max_fill)
   );

   // ------------------------------------------------------------ update
   // The chosen row only grows, so the widest row after the update is the
   // larger of the scanned maximum and the chosen row's new fill.
   assign pad_ext  = (FW+2)'(padding_ff);
   assign new_fill = glrp_pkg::sat_fill((FW+2)'(best_fill) + (FW+2)'(item_ff.item_width)
                                        + pad_ext);
   assign widest   = (new_fill > max_fill) ? new_fill : max_fill;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.row_index     = glrp_pkg::ROW_W'(best_idx);
         rsp_data_in.x_offset      = glrp_pkg::sat_fill((FW+2)'(best_fill) + pad_ext);
         rsp_data_in.batch_done    = item_ff.last_item;
         rsp_data_in.max_row_width = item_ff.last_item
                                     ? glrp_pkg::sat_fill((FW+2)'(widest) + pad_ext)
                                     : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
